@@ rtl/bmp_pkg.sv @@
// Shared types and constants for the 24-bit BMP stream decoder.
package bmp_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL       = 2'd0,
    KIND_BAD_SIG     = 2'd1,
    KIND_UNSUPPORTED = 2'd2
  } kind_e;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned ARGB_W  = 32;

  // Header byte positions (last byte of each little-endian field)
  localparam logic [31:0] POS_SIG_END    = 32'd1;
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_BPP_END    = 32'd29;
  localparam logic [31:0] POS_HDR_END    = 32'd33;
  localparam logic [31:0] MIN_DATA_OFFSET = 32'd34;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BPP_24        = 16'd24;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

  typedef struct packed {
    kind_e                kind;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [ARGB_W-1:0]    argb;
    logic                 last_pixel;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

endpackage

@@ rtl/bmp_in_stage.sv @@
// Input register: holds one accepted byte request until the parser takes it.
module bmp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              file_start_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output bmp_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  bmp_pkg::in_item_t item_q;
  logic              accept;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte  <= data_byte_i;
      item_q.file_start <= file_start_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/bmp_parser.sv @@
// Header parse, offset skip, pixel assembly and row padding; one byte per step.
module bmp_parser #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  bmp_pkg::in_item_t item_i,
  output logic              res_valid_o,
  output bmp_pkg::result_t  res_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [31:0]       pos_q, pos_d;
  logic [31:0]       hdr_q, hdr_d;
  logic [31:0]       offset_q, offset_d;
  logic [DIM_W-1:0]  width_q, width_d;
  logic [DIM_W-1:0]  height_q, height_d;
  logic              fmt_ok_q, fmt_ok_d;
  logic [DIM_W-1:0]  col_q, col_d;
  logic [DIM_W-1:0]  row_q, row_d;
  logic [1:0]        bip_q, bip_d;
  logic [1:0]        pad_q, pad_d;
  logic [7:0]        blue_q, blue_d;
  logic [7:0]        green_q, green_d;

  // state as seen by this byte; file_start restarts the parse
  phase_e            phase_cur;
  logic [31:0]       pos_cur, hdr_cur, hdr_new;
  logic              fmt_cur;
  logic [DIM_W-1:0]  col_cur, row_cur;
  logic [1:0]        bip_cur;
  logic [DIM_W-1:0]  col_inc, row_inc, y_full;
  logic              row_end, img_end;
  logic [DIM_W-1:0]  dim_val;
  logic              dim_ok;
  logic [7:0]        b;

  assign b       = item_i.data_byte;
  assign hdr_new = {b, hdr_cur[31:8]};
  assign dim_ok  = (hdr_new != 32'd0) && (hdr_new <= 32'(MAX_DIM));
  assign dim_val = dim_ok ? hdr_new[DIM_W-1:0] : '0;
  assign col_inc = col_cur + DIM_W'(1);
  assign row_inc = row_cur + DIM_W'(1);
  assign y_full  = height_q - row_cur - DIM_W'(1);
  assign row_end = (col_inc == width_q);
  assign img_end = row_end && (row_inc == height_q);

  always_comb begin
    phase_cur = item_i.file_start ? PH_HEADER : phase_q;
    pos_cur   = item_i.file_start ? '0 : pos_q;
    hdr_cur   = item_i.file_start ? '0 : hdr_q;
    fmt_cur   = item_i.file_start ? 1'b0 : fmt_ok_q;
    col_cur   = item_i.file_start ? '0 : col_q;
    row_cur   = item_i.file_start ? '0 : row_q;
    bip_cur   = item_i.file_start ? '0 : bip_q;
  end

  always_comb begin
    phase_d  = phase_cur;
    pos_d    = pos_cur;
    hdr_d    = hdr_cur;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    fmt_ok_d = fmt_cur;
    col_d    = col_cur;
    row_d    = row_cur;
    bip_d    = bip_cur;
    pad_d    = pad_q;
    blue_d   = blue_q;
    green_d  = green_q;

    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_cur)
      PH_HEADER: begin
        hdr_d = hdr_new;
        pos_d = pos_cur + 32'd1;
        if (pos_cur == bmp_pkg::POS_SIG_END &&
            hdr_new[31:16] != bmp_pkg::BMP_SIGNATURE) begin
          phase_d     = PH_DONE;
          res_valid_o = 1'b1;
          res_o.kind  = bmp_pkg::KIND_BAD_SIG;
        end
        if (pos_cur == bmp_pkg::POS_OFFSET_END) offset_d = hdr_new;
        if (pos_cur == bmp_pkg::POS_WIDTH_END)  width_d  = dim_val;
        if (pos_cur == bmp_pkg::POS_HEIGHT_END) height_d = dim_val;
        if (pos_cur == bmp_pkg::POS_BPP_END) begin
          fmt_ok_d = (hdr_new[31:16] == bmp_pkg::BPP_24);
        end
        if (pos_cur == bmp_pkg::POS_HDR_END) begin
          // compression word is hdr_new here
          if (hdr_new != 32'd0 || !fmt_cur || width_q == '0 || height_q == '0 ||
              offset_q < bmp_pkg::MIN_DATA_OFFSET) begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o.kind  = bmp_pkg::KIND_UNSUPPORTED;
          end else if (offset_q == bmp_pkg::MIN_DATA_OFFSET) begin
            phase_d = PH_PIXEL;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        pos_d = pos_cur + 32'd1;
        if (pos_d == offset_q) phase_d = PH_PIXEL;
      end
      PH_PIXEL: begin
        case (bip_cur)
          2'd0: begin
            blue_d = b;
            bip_d  = 2'd1;
          end
          2'd1: begin
            green_d = b;
            bip_d   = 2'd2;
          end
          default: begin
            bip_d             = 2'd0;
            res_valid_o       = 1'b1;
            res_o.kind        = bmp_pkg::KIND_PIXEL;
            res_o.pixel_x     = bmp_pkg::COORD_W'(col_cur);
            res_o.pixel_y     = bmp_pkg::COORD_W'(y_full);
            res_o.argb        = {bmp_pkg::ALPHA_OPAQUE, b, green_q, blue_q};
            res_o.last_pixel  = img_end;
            if (img_end) begin
              phase_d = PH_DONE;
            end else if (row_end) begin
              col_d = '0;
              row_d = row_inc;
              pad_d = width_q[1:0];
              if (width_q[1:0] != 2'd0) phase_d = PH_PAD;
            end else begin
              col_d = col_inc;
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_d = pad_q - 2'd1;
        if (pad_d == 2'd0) phase_d = PH_PIXEL;
      end
      default: begin
        // idle and done: byte dropped
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      hdr_q    <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      fmt_ok_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      fmt_ok_q <= fmt_ok_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
    end
  end

endmodule

@@ rtl/bmp_out_stage.sv @@
// Result register: holds one result request until the receiver takes it.
module bmp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bmp_pkg::result_t res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bmp_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  bmp_pkg::result_t res_q;

  assign ready_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) valid_d = load_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/bmp24_stream_decoder.sv @@
// Top level of the streaming 24-bit uncompressed BMP decoder.
//
// Input channel: one file byte per request (data_byte_i), with file_start_i
// high on byte 0 of each file; it restarts the parse at any point.
// Output channel: zero or one result per byte. kind_o is pixel, bad signature
// (after byte 1) or unsupported format/size (after byte 33). Pixels come out
// in file order with top-down pixel_y; last_pixel_o marks the final one.
// Both channels: a request moves on a clock edge with valid high, stall low.
// Path: input register, parse step, then the result register for any result.
// Throughput: one byte per cycle while out_stall_i is low, set by the single
// parse step between the input and result registers; no multi-cycle units.
// Stall: while a result waits under out_stall_i, at most one more byte enters
// the input register; after that in_stall_o rises until the result leaves.
// Reset: parse goes idle, both registers empty; bytes before the first
// file_start are dropped, as are bytes after a file's end or an error.
module bmp24_stream_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [31:0] argb_o,
  output logic        last_pixel_o
);

  logic              item_valid;
  bmp_pkg::in_item_t item;
  logic              out_ready;
  logic              step;
  logic              res_valid;
  bmp_pkg::result_t  res, res_out;

  assign step = item_valid & out_ready;

  bmp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bmp_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step & res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign kind_o       = res_out.kind;
  assign pixel_x_o    = res_out.pixel_x;
  assign pixel_y_o    = res_out.pixel_y;
  assign argb_o       = res_out.argb;
  assign last_pixel_o = res_out.last_pixel;

endmodule

@@ rtl/bmp_checker.sv @@
// Port-level checks for the BMP decoder, bound to the top level.
module bmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [11:0] pixel_x_o,
  input logic [11:0] pixel_y_o,
  input logic [31:0] argb_o,
  input logic        last_pixel_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(argb_o) &&
    $stable(last_pixel_o))
    else $error("result changed while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != bmp_pkg::KIND_PIXEL |->
    pixel_x_o == 12'd0 && pixel_y_o == 12'd0 && argb_o == 32'd0 && !last_pixel_o)
    else $error("error result carries pixel data");

  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == bmp_pkg::KIND_PIXEL |-> argb_o[31:24] == 8'hFF)
    else $error("pixel not opaque");

endmodule

bind bmp24_stream_decoder bmp_checker u_bmp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .pixel_x_o    (pixel_x_o),
  .pixel_y_o    (pixel_y_o),
  .argb_o       (argb_o),
  .last_pixel_o (last_pixel_o)
);

@@ tb/bmp24_pixel_checker.sv @@
// Result predictor and comparator for the 24-bit BMP stream decoder.
module bmp24_pixel_checker #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic [31:0] argb_i,
  input  logic        last_pixel_i,
  output int          fails_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_HEADER, ST_SKIP, ST_PIXEL, ST_PAD, ST_DONE
  } parse_st_e;

  parse_st_e         phase;
  logic [31:0]       hdr_pos;
  logic [31:0]       hdr_word;
  logic [31:0]       data_off;
  logic [12:0]       img_w;
  logic [12:0]       img_h;
  logic              bpp_ok;
  logic [11:0]       col;
  logic [11:0]       row;
  logic [1:0]        tri_idx;
  logic [1:0]        pad_left;
  logic [15:0]       blue_green;
  bmp_pkg::result_t  decoded_q[$];
  int                fail_cnt;

  task automatic restart_parse();
    phase      = ST_IDLE;
    hdr_pos    = '0;
    hdr_word   = '0;
    data_off   = '0;
    img_w      = '0;
    img_h      = '0;
    bpp_ok     = 1'b0;
    col        = '0;
    row        = '0;
    tri_idx    = '0;
    pad_left   = '0;
    blue_green = '0;
  endtask

  // unsigned 32-bit dimension, kept only when in 1..MAX_DIM
  function automatic logic [12:0] dim_or_zero(logic [31:0] v);
    if (v >= 32'd1 && v <= MAX_DIM) return v[12:0];
    return '0;
  endfunction

  task automatic push_error(bmp_pkg::kind_e k);
    bmp_pkg::result_t r;
    r      = '0;
    r.kind = k;
    decoded_q.push_back(r);
    phase = ST_DONE;
  endtask

  task automatic decode_byte(logic [7:0] b, logic start);
    bmp_pkg::result_t r;
    logic [12:0]      y13;
    logic             row_end;
    if (start) begin
      restart_parse();
      phase = ST_HEADER;
    end
    case (phase)
      ST_HEADER: begin
        hdr_word = {b, hdr_word[31:8]};
        if (hdr_pos == bmp_pkg::POS_SIG_END &&
            hdr_word[31:16] != bmp_pkg::BMP_SIGNATURE) begin
          push_error(bmp_pkg::KIND_BAD_SIG);
        end else if (hdr_pos == bmp_pkg::POS_HDR_END && (hdr_word != '0 || !bpp_ok ||
                     img_w == '0 || img_h == '0 ||
                     data_off < bmp_pkg::MIN_DATA_OFFSET)) begin
          push_error(bmp_pkg::KIND_UNSUPPORTED);
        end else begin
          if (hdr_pos == bmp_pkg::POS_OFFSET_END) data_off = hdr_word;
          if (hdr_pos == bmp_pkg::POS_WIDTH_END) img_w = dim_or_zero(hdr_word);
          if (hdr_pos == bmp_pkg::POS_HEIGHT_END) img_h = dim_or_zero(hdr_word);
          if (hdr_pos == bmp_pkg::POS_BPP_END) begin
            bpp_ok = (hdr_word[31:16] == bmp_pkg::BPP_24);
          end
          if (hdr_pos == bmp_pkg::POS_HDR_END) begin
            phase = (data_off == bmp_pkg::MIN_DATA_OFFSET) ? ST_PIXEL : ST_SKIP;
          end
          hdr_pos = hdr_pos + 32'd1;
        end
      end
      ST_SKIP: begin
        if (hdr_pos + 32'd1 == data_off) phase = ST_PIXEL;
        hdr_pos = hdr_pos + 32'd1;
      end
      ST_PIXEL: begin
        if (tri_idx == 2'd0) begin
          blue_green[7:0] = b;
          tri_idx = 2'd1;
        end else if (tri_idx == 2'd1) begin
          blue_green[15:8] = b;
          tri_idx = 2'd2;
        end else begin
          tri_idx = 2'd0;
          // rows arrive bottom-up
          y13     = img_h - 13'd1 - {1'b0, row};
          row_end = ({1'b0, col} + 13'd1 == img_w);
          r.kind       = bmp_pkg::KIND_PIXEL;
          r.pixel_x    = col;
          r.pixel_y    = y13[11:0];
          r.argb       = {bmp_pkg::ALPHA_OPAQUE, b, blue_green};
          r.last_pixel = row_end && ({1'b0, row} + 13'd1 == img_h);
          decoded_q.push_back(r);
          if (r.last_pixel) begin
            phase = ST_DONE;
          end else if (row_end) begin
            col      = '0;
            row      = row + 12'd1;
            pad_left = img_w[1:0];
            if (pad_left != 2'd0) phase = ST_PAD;
          end else begin
            col = col + 12'd1;
          end
        end
      end
      ST_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) phase = ST_PIXEL;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic check_result();
    bmp_pkg::result_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("unexpected result, kind", {30'd0, kind_i}, '0);
    end else begin
      want = decoded_q.pop_front();
      if (kind_i != want.kind) report_mismatch("kind", {30'd0, kind_i}, {30'd0, want.kind});
      if (pixel_x_i != want.pixel_x) begin
        report_mismatch("pixel_x", 32'(pixel_x_i), 32'(want.pixel_x));
      end
      if (pixel_y_i != want.pixel_y) begin
        report_mismatch("pixel_y", 32'(pixel_y_i), 32'(want.pixel_y));
      end
      if (argb_i != want.argb) report_mismatch("argb", argb_i, want.argb);
      if (last_pixel_i != want.last_pixel) begin
        report_mismatch("last_pixel", 32'(last_pixel_i), 32'(want.last_pixel));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parse();
      decoded_q.delete();
      fail_cnt = 0;
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      // a result can never belong to a byte taken on the same edge
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) decode_byte(data_byte_i, file_start_i);
      fails_o   <= fail_cnt;
      pending_o <= decoded_q.size();
    end
  end

endmodule

@@ tb/bmp24_stream_decoder_tb.sv @@
// Testbench top for the BMP stream decoder: file stimulus, handshake pacing, verdict.
module bmp24_stream_decoder_tb;

  localparam int MAX_DIM     = 4096;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_ITEMS  = 200;
  localparam int ITEM_TARGET = 760;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte  = '0;
  logic        file_start = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  kind;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [31:0] argb;
  logic        last_pixel;

  int                 fails;
  int                 pending;
  int                 sent_cnt    = 0;
  int                 cycle_cnt   = 0;
  logic               calm        = 1'b0;
  int                 byte_budget = 32'h7fff_ffff;
  bmp_pkg::in_item_t  file_bytes[$];

  bmp24_stream_decoder #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .file_start_i(file_start),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .argb_o      (argb),
    .last_pixel_o(last_pixel)
  );

  bmp24_pixel_checker #(
    .MAX_DIM(MAX_DIM)
  ) i_pixel_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .data_byte_i (data_byte),
    .file_start_i(file_start),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .argb_i      (argb),
    .last_pixel_i(last_pixel),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // byte_budget truncates a file so the next file_start restarts mid-parse
  task automatic add_byte(logic [7:0] b, logic start);
    bmp_pkg::in_item_t it;
    if (byte_budget > 0) begin
      it.data_byte  = b;
      it.file_start = start;
      file_bytes.push_back(it);
      byte_budget--;
    end
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic add_bmp(logic [31:0] width_f, logic [31:0] height_f, logic [31:0] off_f,
                         logic [15:0] sig_f, logic [15:0] bpp_f, logic [31:0] comp_f,
                         int cut);
    logic [7:0] hdr[34];
    int         wi;
    int         hi;
    logic       ok;
    byte_budget = (cut > 0) ? cut : 32'h7fff_ffff;
    wi = width_f;
    hi = height_f;
    ok = sig_f == bmp_pkg::BMP_SIGNATURE && bpp_f == bmp_pkg::BPP_24 && comp_f == '0 &&
         wi >= 1 && wi <= MAX_DIM && hi >= 1 && hi <= MAX_DIM &&
         off_f >= bmp_pkg::MIN_DATA_OFFSET;
    for (int k = 0; k < 34; k++) hdr[k] = 8'($urandom_range(0, 255));
    hdr[0]  = sig_f[7:0];
    hdr[1]  = sig_f[15:8];
    hdr[28] = bpp_f[7:0];
    hdr[29] = bpp_f[15:8];
    for (int k = 0; k < 4; k++) begin
      hdr[10+k] = off_f[8*k +: 8];
      hdr[18+k] = width_f[8*k +: 8];
      hdr[22+k] = height_f[8*k +: 8];
      hdr[30+k] = comp_f[8*k +: 8];
    end
    for (int k = 0; k < 34; k++) add_byte(hdr[k], k == 0);
    if (ok) begin
      for (int k = 34; k < off_f; k++) add_byte(8'($urandom_range(0, 255)), 1'b0);
      for (int r = 0; r < hi; r++) begin
        for (int c = 0; c < 3 * wi; c++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        if (r != hi - 1) begin
          for (int p = 0; p < (wi & 3); p++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      // trailing bytes after the last pixel are dropped
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    byte_budget = 32'h7fff_ffff;
  endtask

  function automatic logic [31:0] bad_dim();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = 32'hffff_ffff;
      2:       v = 32'h8000_0000 | $urandom;
      default: v = MAX_DIM + 1 + $urandom_range(0, 100000);
    endcase
    return v;
  endfunction

  task automatic add_random_file();
    int          sel;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    logic [31:0] comp;
    logic [31:0] val;
    logic [15:0] sig;
    logic [15:0] bpp;
    sel  = $urandom_range(0, 99);
    w    = $urandom_range(1, 9);
    h    = $urandom_range(1, 5);
    off  = $urandom_range(0, 1) ? bmp_pkg::MIN_DATA_OFFSET : $urandom_range(35, 60);
    sig  = bmp_pkg::BMP_SIGNATURE;
    bpp  = bmp_pkg::BPP_24;
    comp = '0;
    if (sel < 5) begin
      add_noise();
    end else begin
      if (sel < 20) begin
        case ($urandom_range(0, 6))
          0: begin
            val = $urandom_range(1, 255);
            sig[7:0] = sig[7:0] ^ val[7:0];
          end
          1: begin
            val = $urandom_range(1, 255);
            sig[15:8] = sig[15:8] ^ val[7:0];
          end
          2: begin
            val = $urandom_range(1, 65535);
            bpp = bpp ^ val[15:0];
          end
          3:       comp = 32'd1 << $urandom_range(0, 31);
          4:       w = bad_dim();
          5:       h = bad_dim();
          default: off = $urandom_range(0, 33);
        endcase
      end
      add_bmp(w, h, off, sig, bpp, comp, (sel >= 20 && sel < 30) ? $urandom_range(2, 70) : 0);
    end
  endtask

  // receiver: short stall bursts plus an occasional long hold-off
  initial begin
    int stall_pct;
    int hold_mark;
    int burst;
    stall_pct = 20;
    hold_mark = 300;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) stall_pct = 20 * $urandom_range(0, 2);
      if (!calm && sent_cnt >= hold_mark) begin
        hold_mark = hold_mark + 3000;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int gap_pct;
    gap_pct = 15;

    // bytes before any file start are dropped
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    // bad signature, first and second byte; the file ends at the signature
    add_bmp(3, 2, 34, 16'h4d41, bmp_pkg::BPP_24, '0, 2);
    add_bmp(3, 2, 34, 16'h4e42, bmp_pkg::BPP_24, '0, 2);
    // unsupported format, sizes and data offset
    add_bmp(3, 2, 34, bmp_pkg::BMP_SIGNATURE, 16'd32, '0, 0);
    add_bmp(3, 2, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, 32'd1, 0);
    add_bmp(0, 2, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(32'hffff_ffff, 2, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(MAX_DIM + 1, 2, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(3, 0, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(3, 32'h8000_0000, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(3, MAX_DIM + 1, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(3, 2, 33, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    // good images: data right after header, skipped gap, padded rows, no padding
    add_bmp(1, 1, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(3, 2, 40, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    add_bmp(4, 2, 37, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 0);
    // restarts in the middle of pixel data and of the header
    add_bmp(5, 2, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 45);
    add_bmp(2, 2, 36, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 20);
    // largest accepted sizes, cut short after the first few pixels
    add_bmp(MAX_DIM, 1, 34, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 40);
    add_bmp(1, MAX_DIM, 50, bmp_pkg::BMP_SIGNATURE, bmp_pkg::BPP_24, '0, 62);

    while (file_bytes.size() < ITEM_TARGET) add_random_file();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i == file_bytes.size() - TAIL_ITEMS) calm <= 1'b1;
      if ($urandom_range(0, 49) == 0) gap_pct = 15 * $urandom_range(0, 3);
      if (!calm && $urandom_range(1, 100) <= gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_valid   <= 1'b1;
      data_byte  <= file_bytes[i].data_byte;
      file_start <= file_bytes[i].file_start;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sent_cnt <= sent_cnt + 1;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
